// File: design/ssrl_pkg.sv
`default_nettype none

package ssrl_pkg;

    // width of the rise and fall step registers
    localparam int STEP_BITS = 13;

    // item kind carried on tuser
    typedef enum logic [1:0] {
        FUNC_TARGET = 2'd0,
        FUNC_TICK   = 2'd1,
        FUNC_ESTOP  = 2'd2
    } func_t;

    // register index (byte address / 4)
    typedef enum logic [2:0] {
        REG_UP_STEP    = 3'd0,
        REG_DOWN_STEP  = 3'd1,
        REG_BAND_LOW   = 3'd2,
        REG_BAND_HIGH  = 3'd3,
        REG_BAND_VALUE = 3'd4,
        REG_STOP_CODE  = 3'd5
    } reg_index_t;

    // register reset values
    localparam int RST_UP_STEP    = 123;
    localparam int RST_DOWN_STEP  = 143;
    localparam int RST_BAND_LOW   = 819;
    localparam int RST_BAND_HIGH  = 2048;
    localparam int RST_BAND_VALUE = 2458;
    localparam int RST_STOP_CODE  = -4096;

endpackage

`default_nettype wire

// File: design/speed_slew_rate_limiter.sv
// Channel   Dir  Handshake           Payload
// s_*       in   s_tvalid/s_tready   tuser = func, tdata = target_speed
// m_*       out  m_tvalid/m_tready   tdata = speed
// apb       in   psel/penable        six registers at byte address 4*i
//
// Two register stages: an input register, then one pass of compare/add logic
// that updates the ramp state and loads the result register. One request per
// cycle sustained while m_tready keeps the result register draining.
// A full result register stalls only tick requests; commands and stops drain.
// rst_n clears speed, target, stop latch, valids; registers return to defaults.
`default_nettype none

module speed_slew_rate_limiter #(
    parameter int SPEED_BITS = 20
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // input stream
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [((SPEED_BITS + 7) / 8) * 8 - 1:0] s_tdata, // [SPEED_BITS-1:0] target_speed
    input  wire logic [1:0]                          s_tuser,  // [1:0] func
    // output stream
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic [((SPEED_BITS + 7) / 8) * 8 - 1:0]  m_tdata,  // [SPEED_BITS-1:0] speed
    // configuration
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [4:0]                          paddr,
    input  wire logic [31:0]                         pwdata,
    output logic [31:0]                              prdata,
    output logic                                     pready
);
    import ssrl_pkg::*;

    localparam int DATA_BITS = ((SPEED_BITS + 7) / 8) * 8;
    // wide enough for speed +/- step without overflow
    localparam int EXT_BITS  = ((SPEED_BITS > STEP_BITS) ? SPEED_BITS : STEP_BITS) + 2;
    localparam logic signed [SPEED_BITS-1:0] SPEED_MAX = {1'b0, {(SPEED_BITS - 1){1'b1}}};
    localparam logic signed [SPEED_BITS-1:0] SPEED_MIN = {1'b1, {(SPEED_BITS - 1){1'b0}}};

    // ---------------- configuration registers ----------------
    logic [STEP_BITS-1:0]         up_step_reg, down_step_reg;
    logic signed [SPEED_BITS-1:0] band_low_reg, band_high_reg, band_value_reg, stop_code_reg;
    logic                         cfg_write;
    reg_index_t                   cfg_index;

    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready;
    assign cfg_index = reg_index_t'(paddr[4:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            up_step_reg    <= STEP_BITS'(RST_UP_STEP);
            down_step_reg  <= STEP_BITS'(RST_DOWN_STEP);
            band_low_reg   <= SPEED_BITS'(RST_BAND_LOW);
            band_high_reg  <= SPEED_BITS'(RST_BAND_HIGH);
            band_value_reg <= SPEED_BITS'(RST_BAND_VALUE);
            stop_code_reg  <= SPEED_BITS'(RST_STOP_CODE);
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_UP_STEP:    up_step_reg    <= pwdata[STEP_BITS-1:0];
                REG_DOWN_STEP:  down_step_reg  <= pwdata[STEP_BITS-1:0];
                REG_BAND_LOW:   band_low_reg   <= pwdata[SPEED_BITS-1:0];
                REG_BAND_HIGH:  band_high_reg  <= pwdata[SPEED_BITS-1:0];
                REG_BAND_VALUE: band_value_reg <= pwdata[SPEED_BITS-1:0];
                REG_STOP_CODE:  stop_code_reg  <= pwdata[SPEED_BITS-1:0];
                default: ;      // addresses past the map are ignored
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_index)
            REG_UP_STEP:    prdata = 32'(up_step_reg);
            REG_DOWN_STEP:  prdata = 32'(down_step_reg);
            REG_BAND_LOW:   prdata = 32'(band_low_reg);
            REG_BAND_HIGH:  prdata = 32'(band_high_reg);
            REG_BAND_VALUE: prdata = 32'(band_value_reg);
            REG_STOP_CODE:  prdata = 32'(stop_code_reg);
            default:        prdata = '0;
        endcase
    end

    // ---------------- stage 1: input register ----------------
    logic                         in_valid_reg;
    logic [1:0]                   in_func_reg;
    logic signed [SPEED_BITS-1:0] in_target_reg;
    logic                         is_tick;
    logic                         adv;      // result register can take a value
    logic                         s2_fire;  // stage-1 request consumed

    assign is_tick  = (in_func_reg == FUNC_TICK);
    assign adv      = ~m_tvalid | m_tready;
    assign s2_fire  = in_valid_reg & (~is_tick | adv);
    assign s_tready = ~in_valid_reg | s2_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_func_reg   <= s_tuser;
            in_target_reg <= s_tdata[SPEED_BITS-1:0];
        end
    end

    // ---------------- stage 2: ramp update ----------------
    logic signed [SPEED_BITS-1:0] current_speed_reg, current_speed_next;
    logic signed [SPEED_BITS-1:0] target_level_reg, target_level_next;
    logic                         stop_latched_reg, stop_latched_next;
    logic                         out_valid_reg, out_valid_next;
    logic signed [SPEED_BITS-1:0] out_speed_reg, out_speed_next;

    logic                         hit_stop, in_band;
    logic signed [EXT_BITS-1:0]   cur_x, tgt_x, up_x, down_x, rise_x, fall_x, lowered_x;
    logic signed [SPEED_BITS-1:0] ramp_speed;

    assign hit_stop = (in_target_reg == stop_code_reg);
    assign in_band  = (in_target_reg > band_low_reg) && (in_target_reg < band_high_reg);

    assign cur_x     = EXT_BITS'(current_speed_reg);
    assign tgt_x     = EXT_BITS'(target_level_reg);
    assign up_x      = signed'(EXT_BITS'(up_step_reg));
    assign down_x    = signed'(EXT_BITS'(down_step_reg));
    assign rise_x    = cur_x + up_x;
    assign fall_x    = cur_x - up_x;   // snap test uses the rise step
    assign lowered_x = cur_x - down_x;

    always_comb
    begin
        priority if (tgt_x > rise_x)
            ramp_speed = (rise_x > EXT_BITS'(SPEED_MAX)) ? SPEED_MAX
                                                         : rise_x[SPEED_BITS-1:0];
        else if (tgt_x < fall_x)
            ramp_speed = (lowered_x < EXT_BITS'(SPEED_MIN)) ? SPEED_MIN
                                                            : lowered_x[SPEED_BITS-1:0];
        else
            ramp_speed = target_level_reg;
    end

    always_comb
    begin
        current_speed_next = current_speed_reg;
        target_level_next  = target_level_reg;
        stop_latched_next  = stop_latched_reg;
        out_valid_next     = out_valid_reg & ~m_tready;
        out_speed_next     = out_speed_reg;
        if (s2_fire)
        begin
            unique case (in_func_reg)
                FUNC_TARGET:
                begin
                    if (hit_stop)
                    begin
                        current_speed_next = '0;
                        target_level_next  = '0;
                    end
                    else
                        target_level_next = in_band ? band_value_reg : in_target_reg;
                end
                FUNC_TICK:
                begin
                    current_speed_next = ramp_speed;
                    out_valid_next     = 1'b1;
                    out_speed_next     = stop_latched_reg ? '0 : ramp_speed;
                end
                FUNC_ESTOP: stop_latched_next = 1'b1;
                default: ;  // unused code: dropped
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            current_speed_reg <= '0;
            target_level_reg  <= '0;
            stop_latched_reg  <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            current_speed_reg <= current_speed_next;
            target_level_reg  <= target_level_next;
            stop_latched_reg  <= stop_latched_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_speed_reg <= out_speed_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = DATA_BITS'(unsigned'(out_speed_reg));

`ifndef ASSERT_OFF
    // stall only when the input register holds a blocked request
    a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> in_valid_reg && is_tick && !adv)
        else $error("input stalled without a blocked tick");

    // emergency stop is sticky until reset
    a_stop_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        stop_latched_reg |=> stop_latched_reg)
        else $error("stop latch cleared");

    // a tick after the stop publishes zero
    a_stop_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_fire && is_tick && stop_latched_reg) |=> (out_speed_reg == '0))
        else $error("nonzero speed while stopped");

    // the stop command zeroes the ramp
    a_stop_code: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_fire && (in_func_reg == FUNC_TARGET) && hit_stop)
            |=> (current_speed_reg == '0) && (target_level_reg == '0))
        else $error("stop code did not zero speed");
`endif

endmodule

`default_nettype wire
